// File: sv/radix_digit_converter_unit_macros.svh
// assertion macros for the radix digit converter
// used by the top level only, no other dependencies
`ifndef RADIX_DIGIT_CONVERTER_UNIT_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdc assertion failed");

// next-cycle implication, disabled in reset
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdc assertion failed");

`endif

// File: sv/rdc_pkg.sv
// shared types, constants and helper functions of the radix digit converter
// no dependencies
`timescale 1ns / 1ps

package rdc_pkg;

    typedef logic [4:0] radix_t;
    typedef logic [3:0] digit_t;
    typedef logic [6:0] char_t;
    typedef logic [6:0] count_t;

    localparam radix_t RADIX_MIN = 5'd2;
    localparam radix_t RADIX_MAX = 5'd16;

    // remainder steps done per clock by the divider
    localparam int DIV_STEPS = 8;

    localparam char_t CHAR_ZERO   = 7'd48;
    localparam char_t CHAR_A_LOW  = 7'd97;

    function automatic radix_t clamp_radix(input radix_t r);
        radix_t res;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        else
        begin
            res = r;
        end
        return res;
    endfunction

    // "0123456789abcdef"
    function automatic char_t digit_to_char(input digit_t d);
        char_t c;
        if (d < 4'd10)
        begin
            c = CHAR_ZERO + 7'(d);
        end
        else
        begin
            c = CHAR_A_LOW + 7'(d - 4'd10);
        end
        return c;
    endfunction

endpackage

// File: sv/rdc_ifs.sv
// valid/ready channel interfaces of the radix digit converter
// depends on rdc_pkg
`timescale 1ns / 1ps

interface rdc_in_if;
    logic                 valid;
    logic                 ready;
    logic [63:0]          value;
    rdc_pkg::radix_t      radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

interface rdc_out_if;
    logic                 valid;
    logic                 ready;
    rdc_pkg::char_t       digit_char;
    rdc_pkg::count_t      digit_count;
    logic                 last;

    modport source (output valid, output digit_char, output digit_count, output last,
                    input ready);
    modport sink   (input valid, input digit_char, input digit_count, input last,
                    output ready);
endinterface

// File: sv/rdc_front.sv
// front end: takes input transfers, masks the value, clamps the radix
// and holds them in a two-entry queue for the back end; depends on rdc_pkg, rdc_ifs
`timescale 1ns / 1ps

module rdc_front #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rdc_in_if.sink                 din,
    output logic                   q_valid,
    input  logic                   q_ready,
    output logic [VALUE_WIDTH-1:0] q_value,
    output rdc_pkg::radix_t        q_radix
);
    import rdc_pkg::*;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    logic [VALUE_WIDTH-1:0] ent_value_reg [2];
    radix_t                 ent_radix_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    logic                   push;
    logic                   pop;

    assign din.ready = (cnt_reg != QUEUE_DEPTH);
    assign push      = din.valid && din.ready;
    assign pop       = q_valid && q_ready;

    assign q_valid = (cnt_reg != 2'd0);
    assign q_value = ent_value_reg[rd_ptr_reg];
    assign q_radix = ent_radix_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_value_reg[wr_ptr_reg] <= din.value[VALUE_WIDTH-1:0];
            ent_radix_reg[wr_ptr_reg] <= clamp_radix(din.radix);
        end
    end

endmodule

// File: sv/rdc_back.sv
// back end: digit-serial division into a digit buffer, then reversed emission
// through an output register; depends on rdc_pkg, rdc_ifs
`timescale 1ns / 1ps

module rdc_back #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [VALUE_WIDTH-1:0] q_value,
    input  rdc_pkg::radix_t        q_radix,
    rdc_out_if.source              dout
);
    import rdc_pkg::*;

    localparam int CHUNKS = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_W  = CHUNKS * DIV_STEPS;
    localparam int CW     = $clog2(CHUNKS) + 1;
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int NW     = $clog2(MAX_DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_SHOW = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PAD_W-1:0] div_reg, div_next;
    digit_t           rem_reg, rem_next;
    radix_t           radix_reg, radix_next;
    logic [CW-1:0]    chunk_reg, chunk_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    idx_reg, idx_next;
    digit_t           rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    char_t            out_char_reg;
    count_t           out_count_reg;
    logic             out_last_reg;
    logic             out_load;

    logic [PAD_W-1:0] div_step;
    digit_t           rem_step;
    logic             wr_en;
    logic             rd_en;

    digit_t           dig_mem [MAX_DIGITS];

    // eight shift-and-subtract remainder steps per clock
    always_comb
    begin
        logic [4:0] trial;
        div_step = div_reg;
        rem_step = rem_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            trial    = {rem_step, div_step[PAD_W-1]};
            div_step = {div_step[PAD_W-2:0], 1'b0};
            if (trial >= radix_reg)
            begin
                trial       = trial - radix_reg;
                div_step[0] = 1'b1;
            end
            rem_step = trial[3:0];
        end
    end

    assign q_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        chunk_next     = chunk_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !dout.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    div_next   = PAD_W'(q_value);
                    radix_next = q_radix;
                    rem_next   = '0;
                    chunk_next = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_next = div_step;
                rem_next = rem_step;
                if (chunk_reg == CW'(CHUNKS - 1))
                begin
                    // remainder is the next digit, quotient stays for the next pass
                    wr_en      = 1'b1;
                    cnt_next   = cnt_reg + NW'(1);
                    chunk_next = '0;
                    rem_next   = '0;
                    if (div_step == '0 || cnt_reg == NW'(MAX_DIGITS - 1))
                    begin
                        idx_next   = cnt_reg[AW-1:0];
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    chunk_next = chunk_reg + CW'(1);
                end
            end
            ST_LOAD:
            begin
                rd_en      = 1'b1;
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        radix_reg <= radix_next;
        chunk_reg <= chunk_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        if (out_load)
        begin
            out_char_reg  <= digit_to_char(rd_data_reg);
            out_count_reg <= 7'(cnt_reg);
            out_last_reg  <= (idx_reg == '0);
        end
    end

    // digit buffer, least significant digit at address zero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dig_mem[cnt_reg[AW-1:0]] <= rem_step;
        end
        if (rd_en)
        begin
            rd_data_reg <= dig_mem[idx_reg];
        end
    end

    assign dout.valid       = out_valid_reg;
    assign dout.digit_char  = out_char_reg;
    assign dout.digit_count = out_count_reg;
    assign dout.last        = out_last_reg;

endmodule

// File: sv/radix_digit_converter_unit.sv
// Converts an unsigned value to lower-case ASCII digits in radix 2 to 16, most
// significant digit first, one digit per output transfer, with the digit count on
// every transfer and last on the final digit. A two-entry queue takes new inputs
// while the back end works. The remainder unit does 8 division steps per cycle
// over C = ceil(VALUE_WIDTH/8) chunks per digit; each digit is then read back from the
// digit buffer into the output register, which holds while the receiver stalls.
// Depends on rdc_pkg, rdc_ifs, rdc_front, rdc_back and the assertion macros.
`timescale 1ns / 1ps
`include "radix_digit_converter_unit_macros.svh"

module radix_digit_converter_unit #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    rdc_in_if.sink    din,
    rdc_out_if.source dout
);
    import rdc_pkg::*;

    logic                   q_valid;
    logic                   q_ready;
    logic [VALUE_WIDTH-1:0] q_value;
    radix_t                 q_radix;

    rdc_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_value (q_value),
        .q_radix (q_radix)
    );

    rdc_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_value (q_value),
        .q_radix (q_radix),
        .dout    (dout)
    );

    // queued radix is always clamped into range
    `RDC_ASSERT_NOW(a_queue_radix, clk, rst_n, q_valid, (q_radix >= RADIX_MIN && q_radix <= RADIX_MAX))

    // digit count stays within the buffer size
    `RDC_ASSERT_NOW(a_count_range, clk, rst_n, dout.valid, (dout.digit_count >= 7'd1 && dout.digit_count <= 7'(MAX_DIGITS)))

    // all digits of one conversion carry the same count
    `RDC_ASSERT_NEXT(a_count_same, clk, rst_n, (dout.valid && dout.ready && !dout.last), (!dout.valid || dout.digit_count == $past(dout.digit_count)))

endmodule

// File: tb/sv/tb_top.sv
// self-checking bench for radix_digit_converter_unit: directed table, then random values
// and radixes, each digit transfer checked against expected digits from the table or a digit predictor
// depends on rdc_pkg, rdc_ifs and the converter top level
`timescale 1ns / 1ps

module tb_top;
    import rdc_pkg::*;

    localparam int VALUE_WIDTH   = 64;
    localparam int MAX_DIGITS    = 64;
    localparam int RANDOM_ITEMS  = 286;
    localparam int LONG_HOLD     = 3000;
    localparam int DRAIN_CYCLES  = 700;
    localparam int LIMIT_CYCLES  = 3000000;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    typedef struct packed {
        logic [63:0] value;
        radix_t      radix;
        bit          typed;
        byte         rep_char;
        int          rep_count;
    } stim_row_t;

    typedef struct packed {
        char_t  ch;
        count_t cnt;
        logic   last;
    } digit_rec_t;

    // typed rows expect rep_count copies of rep_char, other rows use the predictor
    localparam int NUM_ROWS = 24;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{64'd0,                  5'd10, 1'b1, "0", 1},
        '{64'd0,                  5'd2,  1'b1, "0", 1},
        '{64'd0,                  5'd0,  1'b1, "0", 1},
        '{64'd0,                  5'd31, 1'b1, "0", 1},
        '{ALL_ONES,               5'd2,  1'b1, "1", 64},
        '{ALL_ONES,               5'd16, 1'b1, "f", 16},
        '{ALL_ONES,               5'd1,  1'b1, "1", 64},
        '{ALL_ONES,               5'd17, 1'b1, "f", 16},
        '{ALL_ONES,               5'd31, 1'b1, "f", 16},
        '{64'h0000_0000_ffff_ffff, 5'd4, 1'b1, "3", 16},
        '{64'd1,                  5'd2,  1'b1, "1", 1},
        '{64'd9,                  5'd10, 1'b1, "9", 1},
        '{64'd15,                 5'd16, 1'b1, "f", 1},
        '{64'd10,                 5'd16, 1'b1, "a", 1},
        '{ALL_ONES,               5'd10, 1'b0, "0", 0},
        '{ALL_ONES,               5'd8,  1'b0, "0", 0},
        '{ALL_ONES,               5'd3,  1'b0, "0", 0},
        '{64'h8000_0000_0000_0000, 5'd2, 1'b0, "0", 0},
        '{64'h0123_4567_89ab_cdef, 5'd16, 1'b0, "0", 0},
        '{64'd12345,              5'd7,  1'b0, "0", 0},
        '{64'd255,                5'd11, 1'b0, "0", 0},
        '{64'd123456789,          5'd13, 1'b0, "0", 0},
        '{64'd1000,               5'd12, 1'b0, "0", 0},
        '{64'd26,                 5'd5,  1'b0, "0", 0}
    };

    logic clk;
    logic rst_n;
    int   error_count;
    int   cycle_count;
    bit   sender_burst;
    bit   sink_hold_request;

    digit_rec_t pending_digits[$];

    rdc_in_if  din_if();
    rdc_out_if dout_if();

    radix_digit_converter_unit #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (din_if),
        .dout (dout_if)
    );

    always #10 clk = ~clk;

    // digits of value in the clamped radix, most significant first
    function automatic void convert_to_digits(input logic [63:0] value, input radix_t radix_in);
        logic [63:0] rest;
        logic [63:0] base;
        digit_t      d;
        char_t       chars[$];
        digit_rec_t  rec;
        int          n;
        if (radix_in < 5'd2)
        begin
            base = 64'd2;
        end
        else if (radix_in > 5'd16)
        begin
            base = 64'd16;
        end
        else
        begin
            base = 64'(radix_in);
        end
        rest = value & (ALL_ONES >> (64 - VALUE_WIDTH));
        n = 0;
        do
        begin
            d = digit_t'(rest % base);
            chars.push_front(d < 4'd10 ? char_t'(7'd48 + 7'(d)) : char_t'(7'd87 + 7'(d)));
            rest = rest / base;
            n++;
        end
        while (rest != 64'd0 && n < MAX_DIGITS);
        for (int k = 0; k < n; k++)
        begin
            rec.ch   = chars[k];
            rec.cnt  = count_t'(n);
            rec.last = (k == n - 1);
            pending_digits.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // drives one item and returns at the edge where it is accepted
    task automatic offer_item(input logic [63:0] value, input radix_t radix);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_if.valid <= 1'b1;
        din_if.value <= value;
        din_if.radix <= radix;
        do
        begin
            @(posedge clk);
        end
        while (!din_if.ready);
    endtask

    task automatic wait_all_digits();
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (pending_digits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        int          w;
        v = {$urandom(), $urandom()};
        w = $urandom_range(0, 64);
        if ($urandom_range(0, 15) == 0)
        begin
            v = ALL_ONES;
        end
        else if (w < 64)
        begin
            v = v & ((64'd1 << w) - 64'd1);
        end
        return v;
    endfunction

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        sender_burst = 1'b0;
        sink_hold_request = 1'b0;
        din_if.valid = 1'b0;
        din_if.value = '0;
        din_if.radix = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            offer_item(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].radix);
            if (DIRECTED_ROWS[i].typed)
            begin
                for (int k = 0; k < DIRECTED_ROWS[i].rep_count; k++)
                begin
                    pending_digits.push_back('{char_t'(DIRECTED_ROWS[i].rep_char),
                                               count_t'(DIRECTED_ROWS[i].rep_count),
                                               k == DIRECTED_ROWS[i].rep_count - 1});
                end
            end
            else
            begin
                convert_to_digits(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].radix);
            end
        end
        wait_all_digits();

        // receiver goes quiet for a long stretch so the input side backs up
        sink_hold_request = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            logic [63:0] v;
            radix_t      r;
            if (i % 40 == 0)
            begin
                sender_burst = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_ITEMS / 2)
            begin
                wait_all_digits();
            end
            v = random_value();
            r = ($urandom_range(0, 9) == 0) ? radix_t'($urandom_range(0, 31))
                                            : radix_t'($urandom_range(2, 16));
            offer_item(v, r);
            convert_to_digits(v, r);
        end
        wait_all_digits();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // receiver side: random stalls per transfer, burst stretches, one long hold
    initial
    begin
        int gap;
        int taken;
        bit sink_burst;
        dout_if.ready = 1'b0;
        taken = 0;
        sink_burst = 1'b0;
        wait (rst_n);
        forever
        begin
            if (taken % 50 == 0)
            begin
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            gap = sink_burst ? 0 : $urandom_range(0, 17);
            if (sink_hold_request)
            begin
                sink_hold_request = 1'b0;
                gap = LONG_HOLD;
            end
            @(negedge clk);
            if (gap > 0)
            begin
                dout_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            dout_if.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!dout_if.valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (pending_digits.size() == 0)
            begin
                report_mismatch("unexpected digit transfer, char", int'(dout_if.digit_char), 0);
            end
            else
            begin
                digit_rec_t want;
                want = pending_digits.pop_front();
                if (dout_if.digit_char !== want.ch)
                begin
                    report_mismatch("digit_char", int'(dout_if.digit_char), int'(want.ch));
                end
                if (dout_if.digit_count !== want.cnt)
                begin
                    report_mismatch("digit_count", int'(dout_if.digit_count), int'(want.cnt));
                end
                if (dout_if.last !== want.last)
                begin
                    report_mismatch("last", int'(dout_if.last), int'(want.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d digits outstanding",
                     cycle_count, pending_digits.size());
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
    end

endmodule

// File: sim.f
+incdir+sv
sv/rdc_pkg.sv
sv/rdc_ifs.sv
sv/rdc_front.sv
sv/rdc_back.sv
sv/radix_digit_converter_unit.sv
tb/sv/tb_top.sv
